### hdl/pft_pkg.sv
// Shared constants, codes and elaboration-time helpers for the planar frame transform.
package pft_pkg;

	localparam int COORD_WIDTH_DEF   = 32;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_COUNT        = 24;
	localparam int QUEUE_DEPTH       = 4;
	localparam int Z_WIDTH           = 33;
	localparam int XY_WIDTH          = 34;

	localparam logic [1:0] KIND_TO_ABS = 2'd0;
	localparam logic [1:0] KIND_TO_LOC = 2'd1;
	localparam logic [1:0] KIND_VEL    = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// atan(2^-i) in units of 2^-32 turn
	localparam longint ATAN_TURN32 [ATAN_COUNT] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	function automatic int stage_count(input int stages);
		return (stages < ATAN_COUNT) ? stages : ATAN_COUNT;
	endfunction

	function automatic int trig_frac(input int cw);
		return ((62 - cw) < 30) ? (62 - cw) : 30;
	endfunction

	function automatic int word_width(input int cw, input int aw);
		return 2 + 2 + Z_WIDTH + 2 * (cw + 1) + 2 * cw + aw;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		return (a * b + (longint'(1) <<< 29)) >>> 30;
	endfunction

	// inverse CORDIC gain in Q.30, Newton iteration on 1/sqrt(p)
	function automatic longint cordic_gain_inv(input int n);
		longint p;
		longint y;
		longint u;
		p = longint'(1) <<< 30;
		y = 644245094;
		for (int i = 0; i < n; i++) begin
			p = p + (p >>> (2 * i));
		end
		for (int i = 0; i < 6; i++) begin
			u = mul_q30(p, mul_q30(y, y));
			y = mul_q30(y, 3 * (longint'(1) <<< 30) - u) >>> 1;
		end
		return y;
	endfunction

endpackage

### hdl/planar_frame_transform.sv
// Top level of the planar frame transform: front end, queue and CORDIC back end.
//
// Usage: drive kind, the origin pose and the point or pose, and raise start.
// A word is taken at a rising edge where start is high and busy is low.
// Modes: local to absolute, absolute to local, velocity rotation; the unused
// kind code gives an all-zero result.
// Throughput: one word per cycle; busy stays low in steady flow because the
// back end drains the queue every cycle.
// Path from accept to the done strobe: front register, queue, CORDIC load,
// one stage per CORDIC iteration, trig rounding, multiply, sum, saturate.
// Results: done is high for exactly one cycle with out_x, out_y, out_angle
// and saturated valid; the receiver must take the word in that cycle.
// Reset: arst_n clears the queue and all valid flags; no word is in flight
// after reset.
module planar_frame_transform import pft_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    kind,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic [ANGLE_WIDTH-1:0]        origin_angle,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic [ANGLE_WIDTH-1:0]        point_angle,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic [ANGLE_WIDTH-1:0]        out_angle,
	output logic                          saturated
);

	localparam int WORD_W = word_width(COORD_WIDTH, ANGLE_WIDTH);

	logic              accept, push, empty, almost_full;
	logic [WORD_W-1:0] f_word, q_word;

	assign accept = start && !busy;
	assign busy   = almost_full;

	pft_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.WORD_W(WORD_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.kind(kind),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.origin_angle(origin_angle),
		.point_x(point_x),
		.point_y(point_y),
		.point_angle(point_angle),
		.push(push),
		.word(f_word)
	);

	pft_queue #(
		.WIDTH(WORD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(f_word),
		.pop(!empty),
		.rdata(q_word),
		.empty(empty),
		.almost_full(almost_full)
	);

	pft_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES),
		.WORD_W(WORD_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.load(!empty),
		.word(q_word),
		.done(done),
		.out_x(out_x),
		.out_y(out_y),
		.out_angle(out_angle),
		.saturated(saturated)
	);

endmodule

### hdl/pft_front.sv
// Front end: accept an item, reduce the heading to a quadrant and pick the operands.
module pft_front import pft_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
	parameter int WORD_W      = word_width(COORD_WIDTH, ANGLE_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    kind,
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_y,
	input  logic [ANGLE_WIDTH-1:0]        origin_angle,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic [ANGLE_WIDTH-1:0]        point_angle,
	output logic                          push,
	output logic [WORD_W-1:0]             word
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = ANGLE_WIDTH;
	localparam logic [AW-1:0] EIGHTH = AW'(1) << (AW - 3);

	logic [AW-1:0]          a_sum;
	logic [1:0]             q;
	logic [AW-1:0]          ru;
	logic [Z_WIDTH-1:0]     z;
	logic signed [CW:0]     vx, vy;
	logic signed [CW-1:0]   ox, oy;
	logic [AW-1:0]          ang;
	logic                   valid_s1;
	logic [WORD_W-1:0]      word_s1;

	always_comb begin
		a_sum = origin_angle + EIGHTH;
		q     = a_sum[AW-1:AW-2];
		ru    = origin_angle - {q, {(AW-2){1'b0}}};
		z     = {{(Z_WIDTH-AW){ru[AW-1]}}, ru} << (32 - AW);
		vx    = '0;
		vy    = '0;
		ox    = '0;
		oy    = '0;
		ang   = '0;
		case (kind)
			KIND_TO_ABS: begin
				vx  = (CW+1)'(point_x);
				vy  = (CW+1)'(point_y);
				ox  = origin_x;
				oy  = origin_y;
				ang = origin_angle + point_angle;
			end
			KIND_TO_LOC: begin
				vx  = (CW+1)'(point_x) - (CW+1)'(origin_x);
				vy  = (CW+1)'(point_y) - (CW+1)'(origin_y);
				ang = point_angle - origin_angle;
			end
			KIND_VEL: begin
				vx  = (CW+1)'(point_x);
				vy  = (CW+1)'(point_y);
				ang = point_angle;
			end
			default: begin
				vx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= {kind, q, z, vx, vy, ox, oy, ang};
		end
	end

	assign push = valid_s1;
	assign word = word_s1;

endmodule

### hdl/pft_queue.sv
// Short word queue between the front end and the CORDIC back end.
module pft_queue import pft_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             almost_full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [NW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
	end

	assign rdata       = mem[rp_q];
	assign empty       = (cnt_q == '0);
	assign almost_full = (cnt_q >= NW'(DEPTH - 1));

endmodule

### hdl/pft_back.sv
// Back end: pipelined CORDIC, rotation products, rounding, origin add and saturation.
module pft_back import pft_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int WORD_W        = word_width(COORD_WIDTH, ANGLE_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [WORD_W-1:0]             word,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic [ANGLE_WIDTH-1:0]        out_angle,
	output logic                          saturated
);

	localparam int CW   = COORD_WIDTH;
	localparam int AW   = ANGLE_WIDTH;
	localparam int NSTG = stage_count(CORDIC_STAGES);
	localparam int XW   = XY_WIDTH;
	localparam int ZW   = Z_WIDTH;
	localparam int TF   = trig_frac(CW);
	localparam int SH   = 30 - TF;
	localparam int CT   = TF + 2;
	localparam int PRW  = CT + CW + 1;
	localparam int SW   = PRW + 1;
	localparam int PLW  = 2 + 2 + 2 * (CW + 1) + 2 * CW + AW;
	localparam logic signed [XW-1:0] K0    = XW'(cordic_gain_inv(NSTG));
	localparam logic signed [XW-1:0] ONE   = XW'(longint'(1) <<< 30);
	localparam logic signed [XW-1:0] RND_X = (SH == 0) ? '0 : XW'(longint'(1) <<< (SH - 1));
	localparam logic signed [SW-1:0] RND_S = SW'(longint'(1) <<< (TF - 1));
	localparam logic signed [SW-1:0] MAXV  = SW'((longint'(1) <<< (CW - 1)) - 1);
	localparam logic signed [SW-1:0] MINV  = -MAXV - SW'(1);

	logic [1:0]            w_kind, w_q;
	logic [ZW-1:0]         w_z;
	logic [PLW-5:0]        w_pay;
	logic signed [XW-1:0]  x_s [0:NSTG];
	logic signed [XW-1:0]  y_s [0:NSTG];
	logic signed [ZW-1:0]  z_s [0:NSTG];
	logic [PLW-1:0]        pl_s [0:NSTG];
	logic                  v_s [0:NSTG];

	assign {w_kind, w_q, w_z, w_pay} = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s[0]  <= K0;
			y_s[0]  <= '0;
			z_s[0]  <= w_z;
			pl_s[0] <= {w_kind, w_q, w_pay};
		end
	end

	for (genvar i = 0; i < NSTG; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TURN32[i]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			pl_s[i+1] <= pl_s[i];
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - AT;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + AT;
			end
		end
	end

	// clamp to unit range, round to the trig precision, unfold the quadrant
	logic [1:0]            e_kind, e_q;
	logic signed [CW:0]    e_vx, e_vy;
	logic signed [CW-1:0]  e_ox, e_oy;
	logic [AW-1:0]         e_ang;
	logic signed [XW-1:0]  xcl, ycl, xr, yr;
	logic signed [CT-1:0]  xc, yc, cv, sv;

	assign {e_kind, e_q, e_vx, e_vy, e_ox, e_oy, e_ang} = pl_s[NSTG];

	always_comb begin
		xcl = (x_s[NSTG] > ONE) ? ONE : ((x_s[NSTG] < -ONE) ? -ONE : x_s[NSTG]);
		ycl = (y_s[NSTG] > ONE) ? ONE : ((y_s[NSTG] < -ONE) ? -ONE : y_s[NSTG]);
		xr  = (xcl + RND_X) >>> SH;
		yr  = (ycl + RND_X) >>> SH;
		xc  = xr[CT-1:0];
		yc  = yr[CT-1:0];
		case (e_q)
			2'd0: begin
				cv = xc;
				sv = yc;
			end
			2'd1: begin
				cv = -yc;
				sv = xc;
			end
			2'd2: begin
				cv = -xc;
				sv = -yc;
			end
			default: begin
				cv = yc;
				sv = -xc;
			end
		endcase
	end

	logic                  v_s1, v_s2, v_s3;
	logic signed [CT-1:0]  c_s1, s_s1;
	logic signed [CW:0]    vx_s1, vy_s1;
	logic signed [CW-1:0]  ox_s1, oy_s1, ox_s2, oy_s2;
	logic [AW-1:0]         ang_s1, ang_s2, ang_s3;
	logic [1:0]            kind_s1, kind_s2;
	logic signed [PRW-1:0] pcx_s2, psy_s2, pcy_s2, psx_s2;
	logic signed [SW-1:0]  rx_s3, ry_s3;
	logic signed [SW-1:0]  sx, sy, rxa, rya;
	logic                  done_q, sat_q;
	logic signed [CW-1:0]  out_x_q, out_y_q;
	logic [AW-1:0]         out_angle_q;
	logic                  sat_x, sat_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= v_s[NSTG];
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1    <= cv;
		s_s1    <= sv;
		vx_s1   <= e_vx;
		vy_s1   <= e_vy;
		ox_s1   <= e_ox;
		oy_s1   <= e_oy;
		ang_s1  <= e_ang;
		kind_s1 <= e_kind;

		pcx_s2  <= c_s1 * vx_s1;
		psy_s2  <= s_s1 * vy_s1;
		pcy_s2  <= c_s1 * vy_s1;
		psx_s2  <= s_s1 * vx_s1;
		ox_s2   <= ox_s1;
		oy_s2   <= oy_s1;
		ang_s2  <= ang_s1;
		kind_s2 <= kind_s1;

		rx_s3   <= rxa;
		ry_s3   <= rya;
		ang_s3  <= ang_s2;
	end

	always_comb begin
		if (kind_s2 == KIND_TO_LOC) begin
			sx = SW'(pcx_s2) + SW'(psy_s2);
			sy = SW'(pcy_s2) - SW'(psx_s2);
		end else begin
			sx = SW'(pcx_s2) - SW'(psy_s2);
			sy = SW'(psx_s2) + SW'(pcy_s2);
		end
		rxa = ((sx + RND_S) >>> TF) + SW'(ox_s2);
		rya = ((sy + RND_S) >>> TF) + SW'(oy_s2);
		sat_x = (rx_s3 > MAXV) || (rx_s3 < MINV);
		sat_y = (ry_s3 > MAXV) || (ry_s3 < MINV);
	end

	always_ff @(posedge clk) begin
		out_x_q     <= (rx_s3 > MAXV) ? MAXV[CW-1:0] :
		               ((rx_s3 < MINV) ? MINV[CW-1:0] : rx_s3[CW-1:0]);
		out_y_q     <= (ry_s3 > MAXV) ? MAXV[CW-1:0] :
		               ((ry_s3 < MINV) ? MINV[CW-1:0] : ry_s3[CW-1:0]);
		out_angle_q <= ang_s3;
		sat_q       <= sat_x || sat_y;
	end

	assign done      = done_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_angle = out_angle_q;
	assign saturated = sat_q;

endmodule

### hdl/pft_checker.sv
// Port-level checks for the planar frame transform, bound to the top level.
module pft_checker import pft_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [1:0]                    kind,
	input logic                          done,
	input logic signed [COORD_WIDTH-1:0] out_x,
	input logic signed [COORD_WIDTH-1:0] out_y,
	input logic [ANGLE_WIDTH-1:0]        out_angle,
	input logic                          saturated
);

	localparam int LAT = stage_count(CORDIC_STAGES) + 7;
	localparam logic signed [COORD_WIDTH-1:0] MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic acc;
	assign acc = start && !busy && arst_n;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT done)
		else $error("result strobe missing after accepted word");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, LAT))
		else $error("result strobe without accepted word");

	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind == KIND_NONE) |-> ##LAT
		(out_x == '0 && out_y == '0 && out_angle == '0 && !saturated))
		else $error("unused kind gave nonzero result");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
		(out_x == MAXC || out_x == MINC || out_y == MAXC || out_y == MINC))
		else $error("saturated flag without clamped coordinate");

endmodule

bind planar_frame_transform pft_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.ANGLE_WIDTH(ANGLE_WIDTH),
	.CORDIC_STAGES(CORDIC_STAGES)
) u_pft_checker (.*);

### tb/sv/tb_planar_frame_transform.sv
// Self-checking testbench for the planar frame transform: directed table, then random words.
module tb_planar_frame_transform;
	import pft_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int AW = ANGLE_WIDTH_DEF;
	localparam int NSTAGE = CORDIC_STAGES_DEF;
	localparam int LATENCY = NSTAGE + 7;
	localparam int TF = ((62 - CW) < 30) ? (62 - CW) : 30;
	localparam longint ONE = longint'(1) <<< 30;

	typedef struct {
		logic [1:0]           kind;
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic [AW-1:0]        oa;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic [AW-1:0]        pa;
	} pose_word_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [AW-1:0]        ang;
		logic                 sat;
		logic                 known;
	} frame_res_t;

	typedef struct {
		pose_word_t w;
		frame_res_t r;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = KIND_TO_ABS;
	logic signed [CW-1:0] origin_x = '0, origin_y = '0, point_x = '0, point_y = '0;
	logic [AW-1:0] origin_angle = '0, point_angle = '0;
	logic done;
	logic signed [CW-1:0] out_x, out_y;
	logic [AW-1:0] out_angle;
	logic saturated;

	frame_res_t pending_q[$];
	int errors = 0;
	int n_words = 0;
	int n_sat = 0;
	longint gain_k;

	planar_frame_transform u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.origin_x(origin_x), .origin_y(origin_y), .origin_angle(origin_angle),
		.point_x(point_x), .point_y(point_y), .point_angle(point_angle),
		.done(done), .out_x(out_x), .out_y(out_y), .out_angle(out_angle),
		.saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return (a * b + (longint'(1) <<< 29)) >>> 30;
	endfunction

	function automatic longint unit_gain();
		longint p, g, u;
		int n;
		p = ONE;
		g = 644245094;
		n = (NSTAGE < 24) ? NSTAGE : 24;
		for (int i = 0; i < n; i++)
			p = p + (p >>> (2 * i));
		for (int i = 0; i < 6; i++) begin
			u = q30_mul(p, q30_mul(g, g));
			g = q30_mul(g, 3 * ONE - u) >>> 1;
		end
		return g;
	endfunction

	function automatic longint clip_unit(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	// cos and sin of a heading with TF fraction bits
	function automatic void heading_trig(input logic [AW-1:0] a,
		output longint c, output longint s);
		logic [AW-1:0] q, res;
		longint r, x, y, z, dx, dy, xc, yc;
		int n;
		q = ((a + (1 << (AW - 3))) >> (AW - 2)) & 3;
		res = a - q * (1 << (AW - 2));
		r = res;
		if (res[AW-1])
			r -= longint'(1) << AW;
		z = r * (longint'(1) << (32 - AW));
		x = gain_k;
		y = 0;
		n = (NSTAGE < 24) ? NSTAGE : 24;
		for (int i = 0; i < n; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURN32[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURN32[i];
			end
		end
		xc = round_shift(clip_unit(x), 30 - TF);
		yc = round_shift(clip_unit(y), 30 - TF);
		case (q)
			0: begin c = xc; s = yc; end
			1: begin c = -yc; s = xc; end
			2: begin c = -xc; s = -yc; end
			default: begin c = yc; s = -xc; end
		endcase
	endfunction

	function automatic longint clamp_coord(longint v, ref logic flag);
		longint hi, lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin flag = 1'b1; return hi; end
		if (v < lo) begin flag = 1'b1; return lo; end
		return v;
	endfunction

	function automatic frame_res_t transform_pose(pose_word_t w);
		frame_res_t r;
		longint c, s, rx, ry, dx, dy, ox, oy, px, py;
		logic flag;
		r = '{x: '0, y: '0, ang: '0, sat: 1'b0, known: 1'b1};
		if (w.kind == KIND_NONE)
			return r;
		ox = w.ox; oy = w.oy; px = w.px; py = w.py;
		flag = 1'b0;
		heading_trig(w.oa, c, s);
		if (w.kind == KIND_TO_LOC) begin
			dx = px - ox;
			dy = py - oy;
			rx = round_shift(c * dx + s * dy, TF);
			ry = round_shift(c * dy - s * dx, TF);
			r.ang = w.pa - w.oa;
		end else begin
			rx = round_shift(c * px - s * py, TF);
			ry = round_shift(s * px + c * py, TF);
			if (w.kind == KIND_TO_ABS) begin
				rx += ox;
				ry += oy;
				r.ang = w.oa + w.pa;
			end else begin
				r.ang = w.pa;
			end
		end
		r.x = clamp_coord(rx, flag);
		r.y = clamp_coord(ry, flag);
		r.sat = flag;
		return r;
	endfunction

	// check each strobed word against the oldest expectation
	always @(posedge clk) begin
		frame_res_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("unexpected word: x=%0d y=%0d", out_x, out_y);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (out_x !== e.x) begin
					$error("out_x: expected %0d, got %0d", e.x, out_x); errors++;
				end
				if (out_y !== e.y) begin
					$error("out_y: expected %0d, got %0d", e.y, out_y); errors++;
				end
				if (out_angle !== e.ang) begin
					$error("out_angle: expected %0d, got %0d", e.ang, out_angle); errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated: expected %0b, got %0b", e.sat, saturated); errors++;
				end
				if (saturated === 1'b1)
					n_sat++;
			end
		end
	end

	// present one word and hold it until accepted
	task automatic send_word(pose_word_t w, frame_res_t typed);
		frame_res_t p;
		p = transform_pose(w);
		if (typed.known && (p.x !== typed.x || p.y !== typed.y ||
			p.ang !== typed.ang || p.sat !== typed.sat)) begin
			$error("table row disagrees with predictor: x=%0d y=%0d", typed.x, typed.y);
			errors++;
		end
		kind <= w.kind;
		origin_x <= w.ox; origin_y <= w.oy; origin_angle <= w.oa;
		point_x <= w.px; point_y <= w.py; point_angle <= w.pa;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_q.push_back(p);
		n_words++;
		@(negedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CW'({$urandom, $urandom});
			1: return {CW{1'b0}} | $signed($urandom_range(0, 8191)) - 4096;
			2: return $urandom_range(0, 1) ? {1'b0, {CW-1{1'b1}}} : {1'b1, {CW-1{1'b0}}};
			default: return $signed({$urandom} >>> $urandom_range(0, 12));
		endcase
	endfunction

	localparam logic signed [CW-1:0] CMAX = {1'b0, {CW-1{1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {CW-1{1'b0}}};
	localparam logic signed [CW-1:0] UNIT = 1 <<< 12;
	localparam frame_res_t NOCHK = '{x: '0, y: '0, ang: '0, sat: 1'b0, known: 1'b0};

	table_row_t dir_rows[$];
	pose_word_t w;
	int gap;

	initial begin
		gain_k = unit_gain();
		// directed rows: typed results only where obvious
		dir_rows = '{
			'{'{KIND_NONE, CMAX, CMIN, 16'hffff, CMAX, CMIN, 16'hffff},
				'{'0, '0, '0, 1'b0, 1'b1}},
			'{'{KIND_TO_ABS, '0, '0, '0, '0, '0, '0}, '{'0, '0, '0, 1'b0, 1'b1}},
			'{'{KIND_TO_ABS, CMAX, CMAX, '0, CMAX, CMAX, 16'h8000}, NOCHK},
			'{'{KIND_TO_ABS, CMIN, CMIN, 16'h8000, CMAX, CMAX, 16'hffff}, NOCHK},
			'{'{KIND_TO_ABS, 100, -200, 16'h4000, UNIT, '0, 16'h1234}, NOCHK},
			'{'{KIND_TO_ABS, 0, 0, 16'h2000, UNIT, UNIT, 16'hc000}, NOCHK},
			'{'{KIND_TO_LOC, CMIN, CMIN, '0, CMAX, CMAX, '0}, NOCHK},
			'{'{KIND_TO_LOC, CMAX, CMAX, '0, CMIN, CMIN, 16'h0001}, NOCHK},
			'{'{KIND_TO_LOC, CMAX, '0, 16'h8000, CMIN, '0, '0}, NOCHK},
			'{'{KIND_TO_LOC, 5, 7, 16'hc000, 9, -3, 16'hfffe}, NOCHK},
			'{'{KIND_TO_LOC, '0, '0, 16'h1fff, UNIT, -UNIT, 16'h6000}, NOCHK},
			'{'{KIND_VEL, CMAX, CMIN, '0, UNIT, '0, 16'habcd}, NOCHK},
			'{'{KIND_VEL, CMIN, CMAX, 16'h6000, CMAX, CMIN, 16'hffff}, NOCHK},
			'{'{KIND_VEL, '0, '0, 16'he000, CMIN, CMIN, '0}, NOCHK},
			'{'{KIND_VEL, 3, 3, 16'h5fff, -UNIT, UNIT, 16'h8000}, NOCHK},
			'{'{KIND_NONE, '0, '0, '0, '0, '0, '0}, '{'0, '0, '0, 1'b0, 1'b1}}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].r);
		start <= 1'b0;
		// drain fully once before the random part
		while (pending_q.size() != 0)
			@(negedge clk);
		for (int i = 0; i < 750; i++) begin
			if (i < 600 && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				gap = $urandom_range(1, 19);
				repeat (gap) @(negedge clk);
			end
			w.kind = ($urandom_range(0, 15) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
			w.ox = rand_coord(); w.oy = rand_coord();
			w.px = rand_coord(); w.py = rand_coord();
			w.oa = AW'($urandom); w.pa = AW'($urandom);
			send_word(w, NOCHK);
		end
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		$display("covered %0d words in all four kinds, %0d of them saturated",
			n_words, n_sat);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
